// ===== rtl/core/pol_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pol_pkg;

  // Fixed field widths
  localparam int DATA_W     = 32;
  localparam int POS_W      = 8;
  localparam int CMD_W      = 3;
  localparam int OUT_CNT_W  = 5;
  // Widest count or index any allowed capacity needs (capacity up to 127)
  localparam int CNT_MAX_W  = 7;
  // A dump emits at most this many elements
  localparam int DUMP_LIMIT = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_POS   = 3'd5,
    CMD_DUMP      = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } stat_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_DUMP = 1'b1
  } ctrl_state_e;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    cell_op_e              op;
    logic [CNT_MAX_W-1:0]  idx;
    logic [CNT_MAX_W-1:0]  cnt;
    logic [DATA_W-1:0]     data;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/positional_ordered_list.sv =====
// Non-dump commands: the result is registered in the cycle after the command is taken.
// Inserts and deletes shift the cell chain at the same edge that registers the result.
// Dump: one element per cycle while the output is not stalled; the chain rotates once per
// held element, so no new input is taken until every held element has rotated.
// Reset clears the element count and the result valid; cell contents are not reset.
`timescale 1ns / 1ps
`default_nettype none

module positional_ordered_list
  import pol_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [CMD_W-1:0]         cmd_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire logic [POS_W-1:0]         position_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [DATA_W-1:0]      element_o,
  output logic [1:0]                    status_o,
  output logic [OUT_CNT_W-1:0]          count_o,
  output logic                          last_o
);

  cell_cmd_t         cell_cmd;
  logic [DATA_W-1:0] cell_data [CAPACITY];

  pol_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .value_i    (value_i),
    .position_i (position_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .element_o  (element_o),
    .status_o   (status_o),
    .count_o    (count_o),
    .last_o     (last_o),
    .cell_cmd_o (cell_cmd),
    .head_i     (cell_data[0])
  );

  // Chain of cells; each takes from its left or right neighbor, the head or the command data
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    pol_cell #(
      .INDEX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cell_cmd),
      .left_i (left),
      .right_i(right),
      .wrap_i (cell_data[0]),
      .data_o (cell_data[i])
    );
  end

endmodule

`default_nettype wire

// ===== rtl/core/pol_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pol_cell
  import pol_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  wire logic              clk_i,
  input  wire cell_cmd_t         cmd_i,
  input  wire logic [DATA_W-1:0] left_i,
  input  wire logic [DATA_W-1:0] right_i,
  input  wire logic [DATA_W-1:0] wrap_i,
  output logic [DATA_W-1:0]      data_o
);

  localparam logic [CNT_MAX_W-1:0] ME = CNT_MAX_W'(INDEX);

  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] data_d;

  // Pick this cell's next entry from the broadcast command
  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        if (ME == cmd_i.idx) begin
          data_d = cmd_i.data;
        end else if (ME > cmd_i.idx && ME <= cmd_i.cnt) begin
          data_d = left_i;
        end
      end
      CELL_DELETE: begin
        if (ME >= cmd_i.idx && ME + 1'b1 < cmd_i.cnt) begin
          data_d = right_i;
        end
      end
      CELL_ROTATE: begin
        if (ME + 1'b1 < cmd_i.cnt) begin
          data_d = right_i;
        end else if (ME + 1'b1 == cmd_i.cnt) begin
          data_d = wrap_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // Entry storage, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== rtl/core/pol_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pol_ctrl
  import pol_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [CMD_W-1:0]         cmd_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire logic [POS_W-1:0]         position_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [DATA_W-1:0]      element_o,
  output logic [1:0]                    status_o,
  output logic [OUT_CNT_W-1:0]          count_o,
  output logic                          last_o,
  output cell_cmd_t                     cell_cmd_o,
  input  wire logic [DATA_W-1:0]        head_i
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int DUMP_N = (CAPACITY < DUMP_LIMIT) ? CAPACITY : DUMP_LIMIT;
  localparam logic [CNT_W-1:0] CAP_C    = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] DUMP_N_C = CNT_W'(DUMP_N);

  ctrl_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] didx_q, didx_d;

  logic                 out_valid_q, out_valid_d;
  logic [DATA_W-1:0]    elem_q, elem_d;
  stat_e                stat_q, stat_d;
  logic [OUT_CNT_W-1:0] ocnt_q, ocnt_d;
  logic                 last_q, last_d;

  logic             out_ready;
  logic             accept;
  logic             full;
  logic             empty;
  logic [POS_W:0]   pos_ext;
  logic [POS_W:0]   cnt_ext;
  logic [CNT_W-1:0] pos_idx;
  logic [CNT_W-1:0] dump_n;
  logic             emit;
  stat_e            st;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == CS_IDLE && out_ready);
  assign accept     = in_valid_i && !in_stall_o;

  assign full    = (cnt_q == CAP_C);
  assign empty   = (cnt_q == '0);
  assign pos_ext = {1'b0, position_i};
  assign cnt_ext = (POS_W + 1)'(cnt_q);
  assign pos_idx = CNT_W'(position_i - 1'b1);
  assign dump_n  = (cnt_q < DUMP_N_C) ? cnt_q : DUMP_N_C;
  assign emit    = (didx_q < DUMP_N_C);

  // Decode commands, step the dump and load the result register
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    didx_d      = didx_q;
    out_valid_d = out_valid_q && out_stall_i;
    elem_d      = elem_q;
    stat_d      = stat_q;
    ocnt_d      = ocnt_q;
    last_d      = last_q;
    st          = STAT_DONE;
    cell_cmd_o      = '0;
    cell_cmd_o.op   = CELL_HOLD;
    cell_cmd_o.cnt  = CNT_MAX_W'(cnt_q);
    cell_cmd_o.data = value_i;

    case (state_q)
      CS_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_INS_FRONT, CMD_INS_BACK: begin
              if (full) begin
                st = STAT_FULL;
              end else begin
                cell_cmd_o.op  = CELL_INSERT;
                cell_cmd_o.idx = (cmd_i == CMD_INS_FRONT) ? '0 : CNT_MAX_W'(cnt_q);
                cnt_d = cnt_q + 1'b1;
              end
            end
            CMD_INS_POS: begin
              if (pos_ext == '0 || pos_ext > cnt_ext + 1'b1) begin
                st = STAT_BADPOS;
              end else if (full) begin
                st = STAT_FULL;
              end else begin
                cell_cmd_o.op  = CELL_INSERT;
                cell_cmd_o.idx = CNT_MAX_W'(pos_idx);
                cnt_d = cnt_q + 1'b1;
              end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK: begin
              if (empty) begin
                st = STAT_EMPTY;
              end else begin
                cell_cmd_o.op  = CELL_DELETE;
                cell_cmd_o.idx = (cmd_i == CMD_DEL_FRONT) ? '0
                                                          : CNT_MAX_W'(cnt_q - 1'b1);
                cnt_d = cnt_q - 1'b1;
              end
            end
            CMD_DEL_POS: begin
              if (empty) begin
                st = STAT_EMPTY;
              end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                st = STAT_BADPOS;
              end else begin
                cell_cmd_o.op  = CELL_DELETE;
                cell_cmd_o.idx = CNT_MAX_W'(pos_idx);
                cnt_d = cnt_q - 1'b1;
              end
            end
            CMD_DUMP: begin
              if (empty) begin
                st = STAT_EMPTY;
              end
            end
            default: st = STAT_DONE;
          endcase

          if (cmd_i == CMD_DUMP && !empty) begin
            // Start walking the list through the chain
            state_d = CS_DUMP;
            didx_d  = '0;
          end else begin
            out_valid_d = 1'b1;
            elem_d      = '0;
            stat_d      = st;
            ocnt_d      = OUT_CNT_W'(cnt_d);
            last_d      = 1'b1;
          end
        end
      end
      CS_DUMP: begin
        // Rotate one step unless a stalled output holds it; emit the head while under the dump limit
        if (!emit || out_ready) begin
          cell_cmd_o.op = CELL_ROTATE;
          didx_d        = didx_q + 1'b1;
          if (emit) begin
            out_valid_d = 1'b1;
            elem_d      = head_i;
            stat_d      = STAT_DONE;
            ocnt_d      = OUT_CNT_W'(cnt_q);
            last_d      = (didx_q + 1'b1 == dump_n);
          end
          if (didx_q + 1'b1 == cnt_q) begin
            state_d = CS_IDLE;
          end
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      cnt_q       <= '0;
      didx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      didx_q      <= didx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
    stat_q <= stat_d;
    ocnt_q <= ocnt_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign element_o   = elem_q;
  assign status_o    = stat_q;
  assign count_o     = ocnt_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== test/pol_list_checker.sv =====
`timescale 1ns / 1ps

module pol_list_checker
  import pol_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic                     in_stall_i,
  input  wire logic [CMD_W-1:0]         cmd_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire logic [POS_W-1:0]         position_i,
  input  wire logic                     out_valid_i,
  input  wire logic                     out_stall_i,
  input  wire logic signed [DATA_W-1:0] element_i,
  input  wire logic [1:0]               status_i,
  input  wire logic [OUT_CNT_W-1:0]     count_i,
  input  wire logic                     last_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            list_len_o
);

  typedef struct {
    logic signed [DATA_W-1:0] element;
    stat_e                    status;
    logic [OUT_CNT_W-1:0]     count;
    logic                     last;
  } list_result_t;

  // Shadow copy of the list and the results still owed by the block
  list_result_t             owed_results[$];
  logic signed [DATA_W-1:0] shadow_list[CAPACITY];
  int                       shadow_len = 0;
  int                       fails = 0;
  int                       owed_n = 0;

  assign fail_count_o = fails;
  assign pending_o    = owed_n;
  assign list_len_o   = shadow_len;

  task automatic owe_result(input logic signed [DATA_W-1:0] element, input stat_e status,
                            input logic last);
    list_result_t r;
    r.element = element;
    r.status  = status;
    r.count   = shadow_len[OUT_CNT_W-1:0];
    r.last    = last;
    owed_results.push_back(r);
  endtask

  // Open a gap at idx and place v there, unless the list is full
  task automatic shadow_insert(input int idx, input logic signed [DATA_W-1:0] v,
                               output stat_e st);
    if (shadow_len >= CAPACITY) begin
      st = STAT_FULL;
    end else begin
      for (int i = shadow_len; i > idx; i--) shadow_list[i] = shadow_list[i-1];
      shadow_list[idx] = v;
      shadow_len++;
      st = STAT_DONE;
    end
  endtask

  // Close the gap left by entry idx
  task automatic shadow_remove(input int idx);
    for (int i = idx; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
    shadow_len--;
  endtask

  task automatic apply_list_command(input logic [CMD_W-1:0] cmd,
                                    input logic signed [DATA_W-1:0] v,
                                    input logic [POS_W-1:0] position);
    stat_e st;
    int    p;
    int    n;
    st = STAT_DONE;
    p  = int'(position);
    case (cmd)
      CMD_INS_FRONT: shadow_insert(0, v, st);
      CMD_INS_BACK:  shadow_insert(shadow_len, v, st);
      CMD_INS_POS: begin
        if (p < 1 || p > shadow_len + 1) st = STAT_BADPOS;
        else shadow_insert(p - 1, v, st);
      end
      CMD_DEL_FRONT: begin
        if (shadow_len == 0) st = STAT_EMPTY;
        else shadow_remove(0);
      end
      CMD_DEL_BACK: begin
        if (shadow_len == 0) st = STAT_EMPTY;
        else shadow_remove(shadow_len - 1);
      end
      CMD_DEL_POS: begin
        if (shadow_len == 0) st = STAT_EMPTY;
        else if (p < 1 || p > shadow_len) st = STAT_BADPOS;
        else shadow_remove(p - 1);
      end
      CMD_DUMP: begin
        // Emit the front of the list, one result per element up to the dump limit
        if (shadow_len == 0) begin
          owe_result('0, STAT_EMPTY, 1'b1);
        end else begin
          n = (shadow_len > DUMP_LIMIT) ? DUMP_LIMIT : shadow_len;
          for (int i = 0; i < n; i++) owe_result(shadow_list[i], STAT_DONE, i == n - 1);
        end
        return;
      end
      default: ;
    endcase
    owe_result('0, st, 1'b1);
  endtask

  // Check results first, then predict from the input transfer of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      shadow_len = 0;
      owed_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result element=%0d status=%0d count=%0d last=%0d",
                   $time, element_i, status_i, count_i, last_i);
          fails++;
        end else begin
          want = owed_results.pop_front();
          if (element_i !== want.element || status_i !== want.status ||
              count_i !== want.count || last_i !== want.last) begin
            $display({"%0t: mismatch expected element=%0d status=%0d count=%0d last=%0d",
                      " actual element=%0d status=%0d count=%0d last=%0d"},
                     $time, want.element, want.status, want.count, want.last,
                     element_i, status_i, count_i, last_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) apply_list_command(cmd_i, value_i, position_i);
    end
    owed_n = owed_results.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import pol_pkg::*;

  localparam int               CAPACITY     = 16;
  localparam int               RANDOM_ITEMS = 435;
  localparam int               QUIET_ITEMS  = 60;
  localparam int               HOLD_CYCLES  = 300;
  localparam int               IDLE_LIMIT   = 3000;
  localparam int               DRAIN_CYCLES = 20;
  localparam logic [CMD_W-1:0] CMD_UNUSED   = 3'd7;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic [CMD_W-1:0]         cmd       = '0;
  logic signed [DATA_W-1:0] value     = '0;
  logic [POS_W-1:0]         position  = '0;
  logic                     out_stall = 1'b0;
  wire logic                in_stall;
  wire logic                out_valid;
  wire logic signed [DATA_W-1:0] element;
  wire logic [1:0]          status;
  wire logic [OUT_CNT_W-1:0] count;
  wire logic                last;

  int fail_count;
  int pending;
  int list_len;
  bit quiet        = 1'b0;
  bit hold_request = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  positional_ordered_list #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .cmd_i      (cmd),
    .value_i    (value),
    .position_i (position),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .element_o  (element),
    .status_o   (status),
    .count_o    (count),
    .last_o     (last)
  );

  pol_list_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .cmd_i       (cmd),
    .value_i     (value),
    .position_i  (position),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .element_i   (element),
    .status_i    (status),
    .count_i     (count),
    .last_i      (last),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .list_len_o  (list_len)
  );

  // Drop valid while the sender pauses
  task automatic pause_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Offer one command and hold it until the transfer
  task automatic send(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] v,
                      input logic [POS_W-1:0] p);
    if (!quiet && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 18));
    @(negedge clk);
    cmd      <= c;
    value    <= v;
    position <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the sender until every owed result is out
  task automatic wait_list_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // Bias 0 grows the list, bias 1 shrinks it, bias 2 keeps it level
  task automatic send_random_command(input int bias);
    int                       r;
    int                       ins_pct;
    logic [CMD_W-1:0]         c;
    logic [POS_W-1:0]         p;
    r       = $urandom_range(0, 99);
    ins_pct = (bias == 0) ? 65 : (bias == 1) ? 22 : 44;
    if (r < 1) c = CMD_UNUSED;
    else if (r < 9) c = CMD_DUMP;
    else if (r < 9 + ins_pct) begin
      case ($urandom_range(0, 2))
        0:       c = CMD_INS_FRONT;
        1:       c = CMD_INS_BACK;
        default: c = CMD_INS_POS;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       c = CMD_DEL_FRONT;
        1:       c = CMD_DEL_BACK;
        default: c = CMD_DEL_POS;
      endcase
    end
    case ($urandom_range(0, 9))
      0:       p = '0;
      1:       p = POS_W'($urandom_range(0, 255));
      2:       p = POS_W'(list_len + 1);
      3:       p = POS_W'(list_len + 2);
      default: begin
        if (c == CMD_DEL_POS) p = POS_W'($urandom_range(1, (list_len > 0) ? list_len : 1));
        else p = POS_W'($urandom_range(1, list_len + 1));
      end
    endcase
    send(c, pick_value(), p);
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none when quiet
  initial begin
    int burst_left;
    bit burst_stall;
    burst_left  = 0;
    burst_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        if (burst_left == 0) begin
          burst_stall = ($urandom_range(0, 2) == 0);
          burst_left  = burst_stall ? $urandom_range(1, 18) : $urandom_range(1, 24);
        end
        out_stall <= burst_stall;
        burst_left--;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    int bias;
    bias = 2;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Empty list: dump, deletes and positional inserts out of range
    send(CMD_DUMP, '0, '0);
    send(CMD_DEL_FRONT, '0, '0);
    send(CMD_DEL_BACK, '0, '0);
    send(CMD_DEL_POS, '0, 8'd1);
    send(CMD_INS_POS, 32'sd5, 8'd0);
    send(CMD_INS_POS, 32'sd6, 8'd2);

    // Build a short list from the value extremes
    send(CMD_INS_POS, 32'sh7fff_ffff, 8'd1);
    send(CMD_INS_FRONT, 32'sh8000_0000, 8'hff);
    send(CMD_INS_BACK, -1, 8'h00);
    send(CMD_DEL_POS, '0, 8'd0);
    send(CMD_DEL_POS, '0, 8'd4);
    send(CMD_UNUSED, -1, 8'hff);
    send(CMD_INS_POS, 32'sh5555_5555, 8'd4);

    // Fill to capacity, then push against the full list
    for (int i = 0; i < CAPACITY - 4; i++)
      send(i[0] ? CMD_INS_BACK : CMD_INS_FRONT, $urandom, 8'hff);
    send(CMD_INS_FRONT, 32'sd1, '0);
    send(CMD_INS_POS, 32'sd2, 8'd17);
    send(CMD_DUMP, '0, '0);
    send(CMD_DEL_POS, '0, 8'd16);
    send(CMD_DEL_POS, '0, 8'd1);

    // Random commands in growing, shrinking and level phases
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 40 == 0) bias = $urandom_range(0, 2);
      if (k == 150) hold_request = 1'b1;
      if (k == 280) wait_list_drained();
      if (k == RANDOM_ITEMS - QUIET_ITEMS) begin
        wait_list_drained();
        quiet = 1'b1;
      end
      send_random_command(bias);
    end

    wait_list_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pol_pkg.sv
rtl/core/pol_cell.sv
rtl/core/pol_ctrl.sv
rtl/core/positional_ordered_list.sv
test/pol_list_checker.sv
test/tb.sv
